>>> hdl/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Fixed field widths of the input and result words.
  localparam int unsigned ActionW  = 1;
  localparam int unsigned BytesW   = 15;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned StatusW  = 1;

  // Action codes.
  localparam logic [ActionW-1:0] ActAlloc = 1'b0;
  localparam logic [ActionW-1:0] ActFree  = 1'b1;

  // Status codes.
  localparam logic [StatusW-1:0] StOk    = 1'b0;
  localparam logic [StatusW-1:0] StNoMem = 1'b1;

  // Per-field write enables of an arena cell.
  typedef struct packed {
    logic p;
    logic q;
    logic u;
  } wr_mask_t;

  // Sequencer states.
  typedef enum logic [12:0] {
    S_CLR  = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_DIV  = 13'b0000000000100,
    S_ASEN = 13'b0000000001000,
    S_AHDR = 13'b0000000010000,
    S_ALNK = 13'b0000000100000,
    S_FHDR = 13'b0000001000000,
    S_FRPB = 13'b0000010000000,
    S_FDPB = 13'b0000100000000,
    S_FDNB = 13'b0001000000000,
    S_FLNK = 13'b0010000000000,
    S_WR   = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_e;

endpackage

>>> hdl/ffha_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_in_if
// Request channel: one allocate or free word per handshake.
// ----------------------------------------------------------------------------
interface ffha_in_if;
  logic                          valid;
  logic                          ready;
  logic [ffha_pkg::ActionW-1:0]  action;
  logic [ffha_pkg::BytesW-1:0]   request_bytes;
  logic [ffha_pkg::AddrW-1:0]    block_address;

  modport source (output valid, action, request_bytes, block_address, input ready);
  modport sink   (input valid, action, request_bytes, block_address, output ready);
endinterface

>>> hdl/ffha_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_out_if
// Result channel: one status word per request.
// ----------------------------------------------------------------------------
interface ffha_out_if;
  logic                          valid;
  logic                          ready;
  logic [ffha_pkg::StatusW-1:0]  status;
  logic [ffha_pkg::AddrW-1:0]    granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

>>> hdl/ffha_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_mem
// Arena store: one read and one field-masked write per cycle, registered read.
// ----------------------------------------------------------------------------
module ffha_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic               clk_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [AW-1:0]      rd_p_o,
  output logic [AW-1:0]      rd_q_o,
  output logic               rd_u_o,
  input  logic               wr_en_i,
  input  ffha_pkg::wr_mask_t wr_mask_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [AW-1:0]      wr_p_i,
  input  logic [AW-1:0]      wr_q_i,
  input  logic               wr_u_i
);

  logic [AW-1:0] p_mem [DEPTH];
  logic [AW-1:0] q_mem [DEPTH];
  logic          u_mem [DEPTH];

  // Field-masked write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_mask_i.p) p_mem[wr_addr_i] <= wr_p_i;
    if (wr_en_i && wr_mask_i.q) q_mem[wr_addr_i] <= wr_q_i;
    if (wr_en_i && wr_mask_i.u) u_mem[wr_addr_i] <= wr_u_i;
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_p_o <= p_mem[rd_addr_i];
    rd_q_o <= q_mem[rd_addr_i];
    rd_u_o <= u_mem[rd_addr_i];
  end

endmodule

>>> hdl/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit boundary-tag allocator over an arena of units, with a doubly
// linked circular free list and coalescing on free.
// ----------------------------------------------------------------------------
//  Channel | Dir | Word
//  in_i    | in  | action, request_bytes, block_address
//  out_o   | out | status, granted_address
//
// An allocate divides the byte count, walks the free list reading each block's
// size and links, then drains a write list of 3 or 6 arena writes; a free
// reads the header and both neighbors, then drains its write list, or stops
// early when the address is rejected. The arena port does one read and one
// write a cycle. After reset a clearing pass writes all ARENA_UNITS units to
// build the initial arena; no word is taken meanwhile. A result waiting on
// out_o does not stop the next request; a second result waits until it drains.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
  parameter int unsigned ARENA_UNITS = 4096,
  parameter int unsigned UNIT_BYTES  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffha_in_if.sink    in_i,
  ffha_out_if.source out_o
);

  localparam int unsigned AW    = $clog2(ARENA_UNITS);
  localparam int unsigned WW    = ((AW > 16) ? AW : 16) + 2;
  localparam int unsigned SENT  = ARENA_UNITS - 2;
  localparam int unsigned DS    = 20;
  localparam logic [18:0] RECIP = 19'((2**DS + UNIT_BYTES - 1) / UNIT_BYTES);

  typedef struct packed {
    logic [AW-1:0]      addr;
    ffha_pkg::wr_mask_t m;
    logic [AW-1:0]      p;
    logic [AW-1:0]      q;
    logic               u;
  } wr_t;

  // Map an out-of-arena index to unit zero.
  function automatic logic [AW-1:0] ix(input logic [WW-1:0] v);
    logic [AW-1:0] r;
    r = (v < WW'(ARENA_UNITS)) ? v[AW-1:0] : '0;
    return r;
  endfunction

  function automatic logic [WW-1:0] wx(input logic [AW-1:0] v);
    logic [WW-1:0] r;
    r = WW'(v);
    return r;
  endfunction

  function automatic wr_t mk(input logic [AW-1:0] a, input logic mp, input logic mq,
                             input logic mu, input logic [AW-1:0] p,
                             input logic [AW-1:0] q, input logic u);
    wr_t r;
    r.addr = a; r.m.p = mp; r.m.q = mq; r.m.u = mu; r.p = p; r.q = q; r.u = u;
    return r;
  endfunction

  localparam logic [AW-1:0] SentA = AW'(SENT);
  localparam logic [AW-1:0] SentL = AW'(SENT + 1);

  ffha_pkg::state_e state_q, state_d;

  logic [AW-1:0]  clr_q, clr_d;
  logic [15:0]    x_q, x_d;
  logic [35:0]    prod_q, prod_d;
  logic [15:0]    need_q, need_d;
  logic [AW-1:0]  cur_q, cur_d, sz_q, sz_d;
  logic [AW:0]    steps_q, steps_d;
  logic [AW-1:0]  c_q, c_d, pb_q, pb_d, nb_q, nb_d;
  logic [AW-1:0]  szc_q, szc_d, szpb_q, szpb_d, sznb_q, sznb_d;
  logic           pf_q, pf_d, nf_q, nf_d;
  wr_t            wq_q [6];
  wr_t            wq_d [6];
  logic [2:0]     wcnt_q, wcnt_d, widx_q, widx_d;
  logic           rs_q, rs_d;
  logic [ffha_pkg::AddrW-1:0] ra_q, ra_d;
  logic           ov_q, ov_d, os_q, os_d;
  logic [ffha_pkg::AddrW-1:0] oa_q, oa_d;

  logic [AW-1:0]  rd_addr, rd_p, rd_q;
  logic           rd_u;
  logic           wr_en;
  ffha_pkg::wr_mask_t wr_mask;
  logic [AW-1:0]  wr_addr, wr_p, wr_q;
  logic           wr_u;

  logic           in_acc, load;
  logic [WW-1:0]  baddr_w;
  logic [15:0]    q0;
  logic [AW-1:0]  ncur;
  wr_t            ent;

  ffha_mem #(.DEPTH(ARENA_UNITS), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_p_o    (rd_p),
    .rd_q_o    (rd_q),
    .rd_u_o    (rd_u),
    .wr_en_i   (wr_en),
    .wr_mask_i (wr_mask),
    .wr_addr_i (wr_addr),
    .wr_p_i    (wr_p),
    .wr_q_i    (wr_q),
    .wr_u_i    (wr_u)
  );

  assign in_i.ready          = (state_q == ffha_pkg::S_IDLE);
  assign in_acc              = in_i.valid && in_i.ready;
  assign out_o.valid         = ov_q;
  assign out_o.status        = os_q;
  assign out_o.granted_address = oa_q;
  assign baddr_w             = WW'(in_i.block_address);
  assign q0                  = prod_q[DS+15:DS];
  assign ncur                = ix(wx(rd_q));
  assign ent                 = wq_q[widx_q];

  // Sequencer, address generation and write list.
  always_comb begin
    state_d = state_q;  clr_d = clr_q;   x_d = x_q;       prod_d = prod_q;
    need_d = need_q;    cur_d = cur_q;   sz_d = sz_q;     steps_d = steps_q;
    c_d = c_q;          pb_d = pb_q;     nb_d = nb_q;     szc_d = szc_q;
    szpb_d = szpb_q;    sznb_d = sznb_q; pf_d = pf_q;     nf_d = nf_q;
    wq_d = wq_q;        wcnt_d = wcnt_q; widx_d = widx_q;
    rs_d = rs_q;        ra_d = ra_q;     load = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0; wr_mask = '0; wr_addr = '0; wr_p = '0; wr_q = '0; wr_u = 1'b0;

    unique case (state_q)
      // Build the reset arena one unit a cycle.
      ffha_pkg::S_CLR: begin
        wr_en = 1'b1; wr_mask = '1; wr_addr = clr_q;
        if (clr_q == AW'(0)) begin
          wr_p = SentA; wr_q = AW'(ARENA_UNITS - 3);
        end else if (clr_q == AW'(1)) begin
          wr_p = SentA; wr_q = SentA;
        end else if (clr_q == SentA) begin
          wr_u = 1'b1;
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(ARENA_UNITS - 1)) state_d = ffha_pkg::S_IDLE;
      end

      ffha_pkg::S_IDLE: begin
        rd_addr = ix(baddr_w - WW'(1));
        c_d     = ix(baddr_w - WW'(1));
        rs_d    = ffha_pkg::StOk;
        ra_d    = '0;
        if (in_acc) begin
          if (in_i.action == ffha_pkg::ActAlloc) begin
            x_d     = 16'(in_i.request_bytes) + 16'(UNIT_BYTES - 1);
            prod_d  = 36'(x_d) * 36'(RECIP);
            state_d = ffha_pkg::S_DIV;
          end else if (baddr_w == '0 || baddr_w >= WW'(ARENA_UNITS) ||
                       baddr_w == WW'(SENT + 1)) begin
            state_d = ffha_pkg::S_DONE;
          end else begin
            state_d = ffha_pkg::S_FHDR;
          end
        end
      end

      // Correct the reciprocal quotient; fetch the sentinel links.
      ffha_pkg::S_DIV: begin
        rd_addr = SentL;
        need_d  = (21'(q0) * 21'(UNIT_BYTES) > 21'(x_q)) ? q0 - 16'd1 : q0;
        if (need_d == 16'd0) need_d = 16'd1;
        state_d = ffha_pkg::S_ASEN;
      end

      ffha_pkg::S_ASEN: begin
        cur_d   = ncur;
        steps_d = '0;
        rd_addr = ncur;
        if (ncur == SentA) begin
          rs_d = ffha_pkg::StNoMem; state_d = ffha_pkg::S_DONE;
        end else begin
          state_d = ffha_pkg::S_AHDR;
        end
      end

      ffha_pkg::S_AHDR: begin
        sz_d    = rd_q;
        rd_addr = ix(wx(cur_q) + WW'(1));
        state_d = ffha_pkg::S_ALNK;
      end

      // Either take this block or follow its next link.
      ffha_pkg::S_ALNK: begin
        if (wx(sz_q) >= WW'(need_q)) begin
          ra_d = ffha_pkg::AddrW'(wx(cur_q) + WW'(1));
          widx_d = '0;
          if (wx(sz_q) > WW'(need_q) + WW'(2)) begin
            logic [WW-1:0] rem_w;
            logic [AW-1:0] rem;
            rem_w = wx(cur_q) + WW'(need_q) + WW'(1);
            rem   = ix(rem_w);
            wq_d[0] = mk(rem, 1'b1, 1'b1, 1'b1, cur_q,
                         AW'(wx(sz_q) - WW'(need_q) - WW'(1)), 1'b0);
            wq_d[1] = mk(ix(wx(rem) + WW'(1)), 1'b1, 1'b1, 1'b1, rd_p, rd_q, 1'b0);
            wq_d[2] = mk(ix(wx(rd_q) + WW'(1)), 1'b1, 1'b0, 1'b0, rem, '0, 1'b0);
            wq_d[3] = mk(ix(wx(rd_p) + WW'(1)), 1'b0, 1'b1, 1'b0, '0, rem, 1'b0);
            wq_d[4] = mk(ix(wx(cur_q) + wx(sz_q) + WW'(1)), 1'b1, 1'b0, 1'b0,
                         rem, '0, 1'b0);
            wq_d[5] = mk(cur_q, 1'b0, 1'b1, 1'b1, '0, AW'(need_q), 1'b1);
            wcnt_d  = 3'd6;
          end else begin
            wq_d[0] = mk(ix(wx(rd_q) + WW'(1)), 1'b1, 1'b0, 1'b0, rd_p, '0, 1'b0);
            wq_d[1] = mk(ix(wx(rd_p) + WW'(1)), 1'b0, 1'b1, 1'b0, '0, rd_q, 1'b0);
            wq_d[2] = mk(cur_q, 1'b0, 1'b0, 1'b1, '0, '0, 1'b1);
            wcnt_d  = 3'd3;
          end
          state_d = ffha_pkg::S_WR;
        end else begin
          steps_d = steps_q + (AW+1)'(1);
          cur_d   = ncur;
          rd_addr = ncur;
          if (steps_d >= (AW+1)'(ARENA_UNITS) || ncur == SentA) begin
            rs_d = ffha_pkg::StNoMem; state_d = ffha_pkg::S_DONE;
          end else begin
            state_d = ffha_pkg::S_AHDR;
          end
        end
      end

      // Free: check the header and mark it free.
      ffha_pkg::S_FHDR: begin
        if (!rd_u) begin
          state_d = ffha_pkg::S_DONE;
        end else begin
          wr_en = 1'b1; wr_mask.u = 1'b1; wr_addr = c_q; wr_u = 1'b0;
          szc_d   = rd_q;
          pb_d    = ix(wx(rd_p));
          nb_d    = ix(wx(c_q) + wx(rd_q) + WW'(1));
          state_d = ffha_pkg::S_FRPB;
        end
      end

      ffha_pkg::S_FRPB: begin
        rd_addr = pb_q;
        state_d = ffha_pkg::S_FDPB;
      end

      ffha_pkg::S_FDPB: begin
        pf_d    = !rd_u;
        szpb_d  = rd_q;
        rd_addr = nb_q;
        state_d = ffha_pkg::S_FDNB;
      end

      ffha_pkg::S_FDNB: begin
        nf_d    = !rd_u;
        sznb_d  = rd_q;
        rd_addr = (!rd_u) ? ix(wx(nb_q) + WW'(1)) : SentL;
        state_d = ffha_pkg::S_FLNK;
      end

      // Coalesce: pick the write list by which neighbors are free.
      ffha_pkg::S_FLNK: begin
        logic [WW-1:0] ns;
        widx_d = '0;
        ns = '0;
        if (pf_q && !nf_q) begin
          wq_d[0] = mk(pb_q, 1'b0, 1'b1, 1'b0, '0,
                       AW'(wx(szpb_q) + wx(szc_q) + WW'(1)), 1'b0);
          wq_d[1] = mk(nb_q, 1'b1, 1'b0, 1'b0, pb_q, '0, 1'b0);
          wcnt_d  = 3'd2;
        end else if (!pf_q && nf_q) begin
          ns = wx(szc_q) + wx(sznb_q) + WW'(1);
          wq_d[0] = mk(ix(wx(c_q) + WW'(1)), 1'b1, 1'b1, 1'b1, rd_p, rd_q, 1'b0);
          wq_d[1] = mk(ix(wx(rd_p) + WW'(1)), 1'b0, 1'b1, 1'b0, '0, c_q, 1'b0);
          wq_d[2] = mk(ix(wx(rd_q) + WW'(1)), 1'b1, 1'b0, 1'b0, c_q, '0, 1'b0);
          wq_d[3] = mk(c_q, 1'b0, 1'b1, 1'b0, '0, AW'(ns), 1'b0);
          wq_d[4] = mk(ix(wx(c_q) + WW'(AW'(ns)) + WW'(1)), 1'b1, 1'b0, 1'b0,
                       c_q, '0, 1'b0);
          wcnt_d  = 3'd5;
        end else if (pf_q && nf_q) begin
          ns = wx(szpb_q) + wx(szc_q) + wx(sznb_q) + WW'(2);
          wq_d[0] = mk(ix(wx(rd_p) + WW'(1)), 1'b0, 1'b1, 1'b0, '0, rd_q, 1'b0);
          wq_d[1] = mk(ix(wx(rd_q) + WW'(1)), 1'b1, 1'b0, 1'b0, rd_p, '0, 1'b0);
          wq_d[2] = mk(pb_q, 1'b0, 1'b1, 1'b0, '0, AW'(ns), 1'b0);
          wq_d[3] = mk(ix(wx(pb_q) + WW'(AW'(ns)) + WW'(1)), 1'b1, 1'b0, 1'b0,
                       pb_q, '0, 1'b0);
          wcnt_d  = 3'd4;
        end else begin
          wq_d[0] = mk(ix(wx(c_q) + WW'(1)), 1'b1, 1'b1, 1'b1, SentA, rd_q, 1'b0);
          wq_d[1] = mk(SentL, 1'b0, 1'b1, 1'b0, '0, c_q, 1'b0);
          wq_d[2] = mk(ix(wx(rd_q) + WW'(1)), 1'b1, 1'b0, 1'b0, c_q, '0, 1'b0);
          wcnt_d  = 3'd3;
        end
        state_d = ffha_pkg::S_WR;
      end

      // Drain the write list in order, one cell a cycle.
      ffha_pkg::S_WR: begin
        wr_en = 1'b1; wr_mask = ent.m; wr_addr = ent.addr;
        wr_p = ent.p; wr_q = ent.q; wr_u = ent.u;
        widx_d = widx_q + 3'd1;
        if (widx_q == wcnt_q - 3'd1) state_d = ffha_pkg::S_DONE;
      end

      ffha_pkg::S_DONE: begin
        if (!ov_q || out_o.ready) begin
          load    = 1'b1;
          state_d = ffha_pkg::S_IDLE;
        end
      end

      default: state_d = ffha_pkg::S_CLR;
    endcase
  end

  // Output word register.
  always_comb begin
    ov_d = (ov_q && !out_o.ready) || load;
    os_d = load ? rs_q : os_q;
    oa_d = load ? ra_q : oa_q;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_CLR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      widx_q  <= '0;
      wcnt_q  <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      widx_q  <= widx_d;
      wcnt_q  <= wcnt_d;
      steps_q <= steps_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    x_q <= x_d;       prod_q <= prod_d;  need_q <= need_d;
    cur_q <= cur_d;   sz_q <= sz_d;      c_q <= c_d;
    pb_q <= pb_d;     nb_q <= nb_d;      szc_q <= szc_d;
    szpb_q <= szpb_d; sznb_q <= sznb_d;  pf_q <= pf_d;
    nf_q <= nf_d;     wq_q <= wq_d;      rs_q <= rs_d;
    ra_q <= ra_d;     os_q <= os_d;      oa_q <= oa_d;
  end

  // A taken request always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ffha_pkg::S_IDLE)
    else $error("request taken without leaving idle");

  // The write list index stays inside the list.
  a_widx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_WR) |-> (widx_q < wcnt_q))
    else $error("write list index out of range");

  // A failed allocate reports address zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && os_q == ffha_pkg::StNoMem) |-> (oa_q == '0))
    else $error("no-memory result with nonzero address");

endmodule
